>>> design/multi_image_boxcar_mean_macros.svh
// ----------------------------------------------------------------------------
// multi image boxcar mean assertion macros
// shared property shorthands for the filter's checks
// ----------------------------------------------------------------------------
`ifndef MULTI_IMAGE_BOXCAR_MEAN_MACROS_SVH
`define MULTI_IMAGE_BOXCAR_MEAN_MACROS_SVH

// same-cycle implication
`define MBOXC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication
`define MBOXC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> design/mboxc_pkg.sv
// ----------------------------------------------------------------------------
// mboxc_pkg
// sizes, widths and state codes of the boxcar mean filter
// ----------------------------------------------------------------------------
package mboxc_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_WINDOW = 15;
    localparam int MAX_IMAGES = 8;

    localparam int HALF_MAX   = (MAX_WINDOW - 1) / 2;
    localparam int ROW_SLOTS  = MAX_WINDOW - 1;
    localparam int MASK_SLOTS = (HALF_MAX > 0) ? HALF_MAX : 1;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int WID_W    = 11;
    localparam int HALF_W   = $clog2(HALF_MAX + 1);
    localparam int WIN_W    = 4;
    localparam int IMG_W    = $clog2(MAX_IMAGES);
    localparam int NIMG_W   = 4;
    localparam int ROW_W    = 16;
    localparam int SLOT_W   = $clog2(MAX_WINDOW);
    localparam int MSLOT_W  = (MASK_SLOTS > 1) ? $clog2(MASK_SLOTS) : 1;
    localparam int CELL_W   = $clog2(MAX_WINDOW);

    localparam int SAMPLE_W = 32;
    localparam int PIX_W    = SAMPLE_W + $clog2(MAX_IMAGES) + 1;
    localparam int COLSUM_W = PIX_W + $clog2(MAX_WINDOW + 1);
    localparam int TOTAL_W  = COLSUM_W + $clog2(MAX_WINDOW + 1);
    localparam int DIV_W    = $clog2(MAX_IMAGES * MAX_WINDOW * MAX_WINDOW + 1);
    localparam int DCNT_W   = $clog2(TOTAL_W + 1);
    localparam int WORD_W   = ROW_SLOTS * PIX_W + MASK_SLOTS;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_ROWS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COLS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_IMAGES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_ENABLE = 3'd4;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,
        S_COL  = 7'b0000100,
        S_EMIT = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_OUT  = 7'b0100000,
        S_ADV  = 7'b1000000
    } t_state;

    function automatic logic [HALF_W-1:0] half_of(input logic [WIN_W-1:0] w);
        logic [WIN_W-1:0] h;
        h = (w == '0) ? '0 : ((w - WIN_W'(1)) >> 1);
        half_of = (h > WIN_W'(HALF_MAX)) ? HALF_W'(HALF_MAX) : h[HALF_W-1:0];
    endfunction

endpackage

>>> design/multi_image_boxcar_mean.sv
// ----------------------------------------------------------------------------
// multi_image_boxcar_mean
// masked boxcar mean over a window of rows and columns of several images
// ----------------------------------------------------------------------------
// input channel (s): one item per image sample, images of a pixel in order;
//   tdata = sample, tuser = {frame_start, mask_bit}, mask taken from image 0
// output channel (m): tdata = window mean, tlast = last result of the item
// config channel: register index and data, taken only while idle; a write
//   to one of the five registers restarts the frame
// an item that does not complete a pixel is only accumulated; a completing
//   item stops the input while the column sum is built through the line
//   store word, then each result runs through the bit-serial divider (not
//   for masked pixels), so up to 1 + half_cols results per item
// results lag the input by half a window in rows and columns; right edge
//   results are flushed as one run at the last pixel of a row
// reset leaves the registers at width 1024, window 3 by 3, one image, mask
//   off; line store contents are qualified by the row count, no clear pass
// a stalled output holds its item; the next item is accepted meanwhile and
//   processing waits only when a new result is ready to load
// ----------------------------------------------------------------------------
`include "multi_image_boxcar_mean_macros.svh"

module multi_image_boxcar_mean (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [mboxc_pkg::SAMPLE_W-1:0]        i_s_tdata,   // sample
    input  logic [1:0]                            i_s_tuser,   // frame_start, mask_bit
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [mboxc_pkg::SAMPLE_W-1:0]        o_m_tdata,   // mean
    output logic                                  o_m_tlast,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mboxc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mboxc_pkg::CFG_DAT_W-1:0]       i_cfg_data
);

    localparam int PW = mboxc_pkg::PIX_W;
    localparam int CW = mboxc_pkg::COLSUM_W;
    localparam int TW = mboxc_pkg::TOTAL_W;
    localparam int NC = mboxc_pkg::MAX_WINDOW;

    mboxc_pkg::t_state r_state, n_state;

    logic [mboxc_pkg::WID_W-1:0]   r_row_width;
    logic [mboxc_pkg::WIN_W-1:0]   r_win_rows;
    logic [mboxc_pkg::WIN_W-1:0]   r_win_cols;
    logic [mboxc_pkg::NIMG_W-1:0]  r_num_img;
    logic                          r_mask_en;

    logic [mboxc_pkg::IMG_W-1:0]   r_img;
    logic signed [PW-1:0]          r_acc;
    logic                          r_held;
    logic [mboxc_pkg::COL_W-1:0]   r_col;
    logic [mboxc_pkg::ROW_W-1:0]   r_row;
    logic [mboxc_pkg::SLOT_W-1:0]  r_k;
    logic signed [CW-1:0]          r_colsum;
    logic [mboxc_pkg::WORD_W-1:0]  r_word;
    logic [mboxc_pkg::HALF_W-1:0]  r_j;
    logic signed [TW-1:0]          r_total;
    logic [mboxc_pkg::SAMPLE_W-1:0] r_res;
    logic                          r_out_valid;
    logic [mboxc_pkg::SAMPLE_W-1:0] r_out_data;
    logic                          r_out_last;

    logic [mboxc_pkg::WORD_W-1:0]  mem [mboxc_pkg::MAX_WIDTH];

    logic [mboxc_pkg::WID_W-1:0]   eff_width;
    logic [mboxc_pkg::HALF_W-1:0]  hr, hc, jmax;
    logic [mboxc_pkg::NIMG_W-1:0]  eff_n;
    logic [mboxc_pkg::DIV_W-1:0]   divisor;
    logic                          in_acc, cfg_acc, out_acc;
    logic [mboxc_pkg::IMG_W-1:0]   img_eff;
    logic signed [PW-1:0]          acc_new;
    logic                          pix_done;
    logic [mboxc_pkg::SLOT_W-1:0]  two_hr;
    logic                          k_done;
    logic signed [PW-1:0]          slot_k;
    logic [mboxc_pkg::WORD_W-1:0]  word_new;
    logic                          cm;
    logic                          last_col;
    logic                          emit_cond;
    logic                          out_free;

    logic                          cell_shift, cell_clr;
    logic signed [CW-1:0]          cell_in_sum;
    logic                          cell_in_mask;
    logic signed [CW-1:0]          cell_sum  [NC];
    logic                          cell_mask [NC];
    logic signed [CW-1:0]          leaving;
    logic signed [TW-1:0]          total_next;

    logic                          div_start, div_busy, div_done;
    logic [mboxc_pkg::SAMPLE_W-1:0] div_q;

    // effective settings
    assign eff_width = (r_row_width == '0) ? mboxc_pkg::WID_W'(1) :
                       (r_row_width > mboxc_pkg::WID_W'(mboxc_pkg::MAX_WIDTH)) ?
                       mboxc_pkg::WID_W'(mboxc_pkg::MAX_WIDTH) : r_row_width;
    assign hr    = mboxc_pkg::half_of(r_win_rows);
    assign hc    = mboxc_pkg::half_of(r_win_cols);
    assign eff_n = (r_num_img == '0) ? mboxc_pkg::NIMG_W'(1) :
                   (r_num_img > mboxc_pkg::NIMG_W'(mboxc_pkg::MAX_IMAGES)) ?
                   mboxc_pkg::NIMG_W'(mboxc_pkg::MAX_IMAGES) : r_num_img;
    assign divisor = mboxc_pkg::DIV_W'(eff_n)
                   * mboxc_pkg::DIV_W'({hr, 1'b1})
                   * mboxc_pkg::DIV_W'({hc, 1'b1});

    assign o_s_tready  = (r_state == mboxc_pkg::S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == mboxc_pkg::S_IDLE);
    assign in_acc  = i_s_tvalid && o_s_tready;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;
    assign out_acc = r_out_valid && i_m_tready;
    assign out_free = !r_out_valid || i_m_tready;

    // pixel accumulation over images
    assign img_eff  = i_s_tuser[1] ? '0 : r_img;
    assign acc_new  = (img_eff == '0) ? PW'($signed(i_s_tdata))
                                      : r_acc + PW'($signed(i_s_tdata));
    assign pix_done = (mboxc_pkg::NIMG_W'(img_eff) + mboxc_pkg::NIMG_W'(1)) >= eff_n;

    // vertical sum through the line store word
    assign two_hr = mboxc_pkg::SLOT_W'({hr, 1'b0});
    assign k_done = (r_k >= two_hr);

    always_comb begin
        slot_k = '0;
        for (int i = 0; i < mboxc_pkg::ROW_SLOTS; i++) begin
            if (r_k == mboxc_pkg::SLOT_W'(i)) begin
                slot_k = r_word[i*PW +: PW];
            end
        end
    end

    always_comb begin
        word_new = r_word;
        word_new[0 +: PW] = r_acc;
        for (int i = 1; i < mboxc_pkg::ROW_SLOTS; i++) begin
            word_new[i*PW +: PW] = r_word[(i-1)*PW +: PW];
        end
        word_new[mboxc_pkg::ROW_SLOTS*PW] = r_held;
        for (int i = 1; i < mboxc_pkg::MASK_SLOTS; i++) begin
            word_new[mboxc_pkg::ROW_SLOTS*PW + i] = r_word[mboxc_pkg::ROW_SLOTS*PW + i - 1];
        end
    end

    always_comb begin
        cm = r_held;
        if (hr != '0) begin
            cm = 1'b0;
            for (int i = 0; i < mboxc_pkg::MASK_SLOTS; i++) begin
                if ((mboxc_pkg::HALF_W'(i + 1) == hr) && (r_row >= mboxc_pkg::ROW_W'(hr))) begin
                    cm = r_word[mboxc_pkg::ROW_SLOTS*PW + i];
                end
            end
        end
    end

    // horizontal window: chain of column cells with a running total
    assign cell_shift   = ((r_state == mboxc_pkg::S_COL) && k_done)
                       || ((r_state == mboxc_pkg::S_ADV) && (r_j < jmax));
    assign cell_clr     = (r_state == mboxc_pkg::S_COL) && (r_col == '0);
    assign cell_in_sum  = (r_state == mboxc_pkg::S_COL) ? r_colsum : '0;
    assign cell_in_mask = (r_state == mboxc_pkg::S_COL) ? cm : 1'b0;

    always_comb begin
        leaving = '0;
        for (int i = 0; i < NC; i++) begin
            if (mboxc_pkg::CELL_W'(i) == mboxc_pkg::CELL_W'({hc, 1'b0})) begin
                leaving = cell_sum[i];
            end
        end
    end

    assign total_next = (cell_clr ? TW'(0) : r_total) + TW'(cell_in_sum)
                      - (cell_clr ? TW'(0) : TW'(leaving));

    for (genvar g = 0; g < NC; g++) begin : g_cell
        logic signed [CW-1:0] src_sum;
        logic                 src_mask;
        if (g == 0) begin : g_head
            assign src_sum  = cell_in_sum;
            assign src_mask = cell_in_mask;
        end else begin : g_body
            assign src_sum  = cell_sum[g-1];
            assign src_mask = cell_mask[g-1];
        end
        mboxc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (cell_shift),
            .i_clr   (cell_clr && (g != 0)),
            .i_sum   (src_sum),
            .i_mask  (src_mask),
            .o_sum   (cell_sum[g]),
            .o_mask  (cell_mask[g])
        );
    end

    // result selection
    assign last_col  = (mboxc_pkg::WID_W'(r_col) + mboxc_pkg::WID_W'(1)) >= eff_width;
    assign jmax      = last_col ? hc : '0;
    assign emit_cond = (r_row >= mboxc_pkg::ROW_W'(hr))
                    && ((mboxc_pkg::WID_W'(r_col) + mboxc_pkg::WID_W'(r_j))
                        >= mboxc_pkg::WID_W'(hc));

    logic centre_mask;
    always_comb begin
        centre_mask = 1'b0;
        for (int i = 0; i <= mboxc_pkg::HALF_MAX; i++) begin
            if (mboxc_pkg::HALF_W'(i) == hc) begin
                centre_mask = cell_mask[i];
            end
        end
    end

    assign div_start = (r_state == mboxc_pkg::S_EMIT) && emit_cond
                    && (!r_mask_en || centre_mask);

    mboxc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_total),
        .i_divisor  (divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mboxc_pkg::S_IDLE: begin
                if (in_acc && pix_done) n_state = mboxc_pkg::S_RD;
            end
            mboxc_pkg::S_RD:   n_state = mboxc_pkg::S_COL;
            mboxc_pkg::S_COL: begin
                if (k_done) n_state = mboxc_pkg::S_EMIT;
            end
            mboxc_pkg::S_EMIT: begin
                if (!emit_cond)     n_state = mboxc_pkg::S_ADV;
                else if (div_start) n_state = mboxc_pkg::S_DIV;
                else                n_state = mboxc_pkg::S_OUT;
            end
            mboxc_pkg::S_DIV: begin
                if (div_done) n_state = mboxc_pkg::S_OUT;
            end
            mboxc_pkg::S_OUT: begin
                if (out_free) n_state = mboxc_pkg::S_ADV;
            end
            mboxc_pkg::S_ADV: begin
                n_state = (r_j < jmax) ? mboxc_pkg::S_EMIT : mboxc_pkg::S_IDLE;
            end
            default: n_state = mboxc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mboxc_pkg::S_IDLE;
            r_row_width <= mboxc_pkg::WID_W'(1024);
            r_win_rows  <= mboxc_pkg::WIN_W'(3);
            r_win_cols  <= mboxc_pkg::WIN_W'(3);
            r_num_img   <= mboxc_pkg::NIMG_W'(1);
            r_mask_en   <= 1'b0;
            r_img       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_k         <= '0;
            r_j         <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == mboxc_pkg::S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_acc) begin
                unique case (i_cfg_index)
                    mboxc_pkg::REG_ROW_WIDTH:   r_row_width <= i_cfg_data;
                    mboxc_pkg::REG_WINDOW_ROWS: r_win_rows  <= i_cfg_data[mboxc_pkg::WIN_W-1:0];
                    mboxc_pkg::REG_WINDOW_COLS: r_win_cols  <= i_cfg_data[mboxc_pkg::WIN_W-1:0];
                    mboxc_pkg::REG_NUM_IMAGES:  r_num_img   <= i_cfg_data[mboxc_pkg::NIMG_W-1:0];
                    mboxc_pkg::REG_MASK_ENABLE: r_mask_en   <= i_cfg_data[0];
                    default: ;
                endcase
                if (i_cfg_index <= mboxc_pkg::REG_MASK_ENABLE) begin
                    r_img <= '0;
                    r_col <= '0;
                    r_row <= '0;
                end
            end
            unique case (r_state)
                mboxc_pkg::S_IDLE: begin
                    if (in_acc) begin
                        if (i_s_tuser[1]) begin
                            r_col <= '0;
                            r_row <= '0;
                        end
                        r_img <= pix_done ? '0 : img_eff + mboxc_pkg::IMG_W'(1);
                    end
                end
                mboxc_pkg::S_RD: r_k <= '0;
                mboxc_pkg::S_COL: begin
                    if (!k_done) begin
                        r_k <= r_k + mboxc_pkg::SLOT_W'(1);
                    end else begin
                        r_total <= total_next;
                        r_j     <= '0;
                    end
                end
                mboxc_pkg::S_ADV: begin
                    if (r_j < jmax) begin
                        r_j     <= r_j + mboxc_pkg::HALF_W'(1);
                        r_total <= total_next;
                    end else if (last_col) begin
                        r_col <= '0;
                        if (r_row != '1) r_row <= r_row + mboxc_pkg::ROW_W'(1);
                    end else begin
                        r_col <= r_col + mboxc_pkg::COL_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if ((r_state == mboxc_pkg::S_IDLE) && in_acc) begin
            r_acc <= acc_new;
            if (img_eff == '0) r_held <= i_s_tuser[0];
        end
        if (r_state == mboxc_pkg::S_RD) begin
            r_colsum <= CW'(r_acc);
        end else if ((r_state == mboxc_pkg::S_COL) && !k_done
                     && (mboxc_pkg::ROW_W'(r_k) < r_row)) begin
            r_colsum <= r_colsum + CW'(slot_k);
        end
        if ((r_state == mboxc_pkg::S_EMIT) && !div_start) r_res <= '0;
        if (div_done) r_res <= div_q;
        if ((r_state == mboxc_pkg::S_OUT) && out_free) begin
            r_out_data <= r_res;
            r_out_last <= (r_j == jmax);
        end
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (r_state == mboxc_pkg::S_RD) begin
            r_word <= mem[r_col];
        end
        if ((r_state == mboxc_pkg::S_COL) && k_done) begin
            mem[r_col] <= word_new;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    `MBOXC_ASSERT_IMP(a_img_range, i_clk, i_rst_n, 1'b1, mboxc_pkg::NIMG_W'(r_img) < eff_n)
    `MBOXC_ASSERT_IMP(a_div_owner, i_clk, i_rst_n, div_busy, r_state == mboxc_pkg::S_DIV)
    `MBOXC_ASSERT_NXT(a_col_range, i_clk, i_rst_n, 1'b1, mboxc_pkg::WID_W'(r_col) < eff_width)

endmodule

>>> design/mboxc_cell.sv
// ----------------------------------------------------------------------------
// mboxc_cell
// one column of the horizontal window: column sum and centre mask bit
// ----------------------------------------------------------------------------
module mboxc_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_shift,
    input  logic                                i_clr,
    input  logic signed [mboxc_pkg::COLSUM_W-1:0] i_sum,
    input  logic                                i_mask,
    output logic signed [mboxc_pkg::COLSUM_W-1:0] o_sum,
    output logic                                o_mask
);

    logic signed [mboxc_pkg::COLSUM_W-1:0] r_sum;
    logic                                  r_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_mask <= 1'b0;
        end else if (i_shift) begin
            r_sum  <= i_clr ? '0 : i_sum;
            r_mask <= i_clr ? 1'b0 : i_mask;
        end
    end

    assign o_sum  = r_sum;
    assign o_mask = r_mask;

endmodule

>>> design/mboxc_div.sv
// ----------------------------------------------------------------------------
// mboxc_div
// restoring divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module mboxc_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [mboxc_pkg::TOTAL_W-1:0] i_dividend,
    input  logic [mboxc_pkg::DIV_W-1:0]          i_divisor,
    output logic                                 o_busy,
    output logic                                 o_done,
    output logic [mboxc_pkg::SAMPLE_W-1:0]       o_quot
);

    localparam int TW = mboxc_pkg::TOTAL_W;
    localparam int DW = mboxc_pkg::DIV_W;

    logic [TW-1:0]                   r_quo;
    logic [DW-1:0]                   r_rem;
    logic [DW-1:0]                   r_den;
    logic                            r_neg;
    logic                            r_busy;
    logic                            r_done;
    logic [mboxc_pkg::DCNT_W-1:0]    r_cnt;
    logic [DW:0]                     trial;
    logic                            fits;
    logic [TW-1:0]                   quo_next;
    logic [TW-1:0]                   signed_q;

    assign trial    = {r_rem, r_quo[TW-1]};
    assign fits     = trial >= {1'b0, r_den};
    assign quo_next = {r_quo[TW-2:0], fits};
    assign signed_q = r_neg ? (~r_quo + TW'(1)) : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= mboxc_pkg::DCNT_W'(TW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - mboxc_pkg::DCNT_W'(1);
                if (r_cnt == mboxc_pkg::DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[TW-1];
            r_quo <= i_dividend[TW-1] ? (~i_dividend + TW'(1)) : i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];
            r_quo <= quo_next;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = signed_q[mboxc_pkg::SAMPLE_W-1:0];

endmodule

>>> tb/multi_image_boxcar_mean_checker.sv
// ----------------------------------------------------------------------------
// multi_image_boxcar_mean_checker
// watches the sample, mean and register channels of the boxcar mean filter,
// keeps its own model of line stores and window sums, predicts every mean
// and compares it with what the filter delivers
// ----------------------------------------------------------------------------
module multi_image_boxcar_mean_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    input  logic [mboxc_pkg::SAMPLE_W-1:0]      i_s_tdata,
    input  logic [1:0]                          i_s_tuser,
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    input  logic [mboxc_pkg::SAMPLE_W-1:0]      i_m_tdata,
    input  logic                                i_m_tlast,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [mboxc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mboxc_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_mean_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [mboxc_pkg::SAMPLE_W-1:0] mean;
        logic                           last;
    } t_mean;

    t_mean    pending_means[$];

    logic [mboxc_pkg::WID_W-1:0]  row_width;
    logic [mboxc_pkg::WIN_W-1:0]  win_rows;
    logic [mboxc_pkg::WIN_W-1:0]  win_cols;
    logic [mboxc_pkg::NIMG_W-1:0] num_images;
    logic                         mask_en;

    longint   pix_sum;
    longint   row_store [mboxc_pkg::ROW_SLOTS][mboxc_pkg::MAX_WIDTH];
    bit       mask_store [mboxc_pkg::MASK_SLOTS][mboxc_pkg::MAX_WIDTH];
    longint   col_sums [mboxc_pkg::MAX_WINDOW];
    bit       col_mask [mboxc_pkg::MAX_WINDOW];
    int       img_idx;
    int       col_idx;
    int       row_idx;
    bit       held_mask;

    assign o_pending = pending_means.size();

    function automatic int half_size(input logic [mboxc_pkg::WIN_W-1:0] w);
        int h;
        h = (w == 0) ? 0 : (int'(w) - 1) / 2;
        return (h > mboxc_pkg::HALF_MAX) ? mboxc_pkg::HALF_MAX : h;
    endfunction

    task automatic wipe_frame();
        pix_sum    = 0;
        row_store  = '{default: 0};
        mask_store = '{default: 0};
        col_sums   = '{default: 0};
        col_mask   = '{default: 0};
        img_idx    = 0;
        col_idx    = 0;
        row_idx    = 0;
        held_mask  = 0;
    endtask

    task automatic push_column(input longint sum, input bit m);
        for (int k = mboxc_pkg::MAX_WINDOW - 1; k > 0; k--) begin
            col_sums[k] = col_sums[k-1];
            col_mask[k] = col_mask[k-1];
        end
        col_sums[0] = sum;
        col_mask[0] = m;
    endtask

    task automatic absorb_sample(input logic [mboxc_pkg::SAMPLE_W-1:0] smp, input bit msk,
                                 input bit fs);
        int     width, hr, hc, n, c, jmax, cnt;
        longint divisor, colsum, total;
        bit     cm, last;
        t_mean  run [8];
        width = (row_width == 0) ? 1 :
                ((row_width > mboxc_pkg::MAX_WIDTH) ? mboxc_pkg::MAX_WIDTH : row_width);
        hr = half_size(win_rows);
        hc = half_size(win_cols);
        n = (num_images == 0) ? 1 :
            ((num_images > mboxc_pkg::MAX_IMAGES) ? mboxc_pkg::MAX_IMAGES : num_images);
        divisor = longint'(n) * (2 * hr + 1) * (2 * hc + 1);
        cnt = 0;
        if (fs) wipe_frame();
        if (img_idx == 0) begin
            pix_sum = longint'($signed(smp));
            held_mask = msk;
        end else begin
            pix_sum += longint'($signed(smp));
        end
        if (img_idx + 1 < n) begin
            img_idx++;
            return;
        end
        img_idx = 0;
        c = (col_idx >= width) ? width - 1 : col_idx;
        colsum = pix_sum;
        for (int k = 0; k < 2 * hr; k++) colsum += row_store[k][c];
        for (int k = 2 * hr; k > 1; k--) row_store[k-1][c] = row_store[k-2][c];
        if (hr > 0) row_store[0][c] = pix_sum;
        if (hr == 0) begin
            cm = held_mask;
        end else begin
            cm = mask_store[hr-1][c];
            for (int k = hr; k > 1; k--) mask_store[k-1][c] = mask_store[k-2][c];
            mask_store[0][c] = held_mask;
        end
        if (c == 0) begin
            col_sums = '{default: 0};
            col_mask = '{default: 0};
        end
        push_column(colsum, cm);
        last = (c + 1 >= width);
        jmax = last ? hc : 0;
        for (int j = 0; j <= jmax; j++) begin
            if (j > 0) push_column(0, 0);
            if (row_idx >= hr && c + j >= hc) begin
                total = 0;
                if (!mask_en || col_mask[hc]) begin
                    for (int k = 0; k <= 2 * hc; k++) total += col_sums[k];
                    total = total / divisor;
                end
                run[cnt].mean = total[mboxc_pkg::SAMPLE_W-1:0];
                run[cnt].last = 1'b0;
                cnt++;
            end
        end
        for (int i = 0; i < cnt; i++) begin
            run[i].last = (i == cnt - 1);
            pending_means.push_back(run[i]);
        end
        if (last) begin
            col_idx = 0;
            if (row_idx < 16'hFFFF) row_idx++;
        end else begin
            col_idx = c + 1;
        end
    endtask

    always @(posedge i_clk) begin
        t_mean exp_mean;
        if (!i_rst_n) begin
            row_width  = 11'd1024;
            win_rows   = 4'd3;
            win_cols   = 4'd3;
            num_images = 4'd1;
            mask_en    = 1'b0;
            wipe_frame();
            pending_means.delete();
            o_fail_count = 0;
            o_mean_count = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                o_mean_count++;
                if (pending_means.size() == 0) begin
                    $display("%0t: unexpected mean item %h last %b", $time,
                             i_m_tdata, i_m_tlast);
                    o_fail_count++;
                end else begin
                    exp_mean = pending_means.pop_front();
                    if (exp_mean.mean !== i_m_tdata || exp_mean.last !== i_m_tlast) begin
                        $display("%0t: mean mismatch: expected %h last %b, actual %h last %b",
                                 $time, exp_mean.mean, exp_mean.last, i_m_tdata, i_m_tlast);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    mboxc_pkg::REG_ROW_WIDTH: begin
                        row_width = i_cfg_data;
                        wipe_frame();
                    end
                    mboxc_pkg::REG_WINDOW_ROWS: begin
                        win_rows = i_cfg_data[3:0];
                        wipe_frame();
                    end
                    mboxc_pkg::REG_WINDOW_COLS: begin
                        win_cols = i_cfg_data[3:0];
                        wipe_frame();
                    end
                    mboxc_pkg::REG_NUM_IMAGES: begin
                        num_images = i_cfg_data[3:0];
                        wipe_frame();
                    end
                    mboxc_pkg::REG_MASK_ENABLE: begin
                        mask_en = i_cfg_data[0];
                        wipe_frame();
                    end
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                absorb_sample(i_s_tdata, i_s_tuser[0], i_s_tuser[1]);
        end
    end

endmodule

>>> tb/multi_image_boxcar_mean_test.sv
// ----------------------------------------------------------------------------
// multi_image_boxcar_mean_test
// drives raster streams of multi-image samples through the boxcar mean
// filter over a series of register settings, with bursty input, random and
// long output stalls; the checker predicts and compares every mean
// ----------------------------------------------------------------------------
module multi_image_boxcar_mean_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PHASES = 9;
    localparam int IDLE_WAIT  = 700;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_OFF   = 400;

    // register indexes that hold no register
    localparam logic [mboxc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [mboxc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [mboxc_pkg::SAMPLE_W-1:0]      s_tdata;
    logic [1:0]                          s_tuser;
    logic                                m_tvalid;
    logic                                m_tready;
    logic [mboxc_pkg::SAMPLE_W-1:0]      m_tdata;
    logic                                m_tlast;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [mboxc_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [mboxc_pkg::CFG_DAT_W-1:0]     cfg_data;
    int                                  fail_count;
    int                                  pending;
    int                                  mean_count;
    int                                  items_sent;
    int                                  burst_left;
    int                                  quiet_cycles;

    // width, window rows, window cols, images, mask enable, item count
    int ph_width [NUM_PHASES] = '{1024, 4,    0, 2047,  3,  5,  6,  2,  9};
    int ph_rows  [NUM_PHASES] = '{3,    3,    1,   15, 15,  4,  5,  2,  1};
    int ph_cols  [NUM_PHASES] = '{3,    3,    1,   15, 15,  6,  7, 15, 15};
    int ph_imgs  [NUM_PHASES] = '{1,    1,    1,    8,  2,  0,  3,  9,  1};
    int ph_mask  [NUM_PHASES] = '{0,    1,    0,    1,  1,  1,  0,  1,  1};
    int ph_items [NUM_PHASES] = '{8,   20,    8,   12, 60, 20, 45, 30, 27};

    multi_image_boxcar_mean DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    multi_image_boxcar_mean_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_mean_count (mean_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [mboxc_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'(signed'($urandom_range(0, 8)) - 4);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic [mboxc_pkg::SAMPLE_W-1:0] smp, input bit msk,
                             input bit fs);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= {fs, msk};
        @(negedge i_clk);
        while (!s_tready) @(negedge i_clk);
        @(posedge i_clk);
        items_sent++;
        burst_left--;
    endtask

    task automatic write_reg(input logic [mboxc_pkg::CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= mboxc_pkg::CFG_DAT_W'(value);
        @(negedge i_clk);
        while (!cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    // receiver: random stall patterns, stall-free stretches, one long hold-off
    initial begin
        bit held;
        int mode;
        held = 0;
        m_tready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!held && items_sent >= 130) begin
                held = 1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF) @(posedge i_clk);
            end
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(10, 80)) begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    default: m_tready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("multi_image_boxcar_mean_test NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [mboxc_pkg::SAMPLE_W-1:0] edge_vals [8];
        edge_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
                      32'h0001_0000, 32'hFFFF_0000, 32'h5555_5555, 32'hAAAA_AAAA};
        i_rst_n    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        items_sent = 0;
        burst_left = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                s_tvalid <= 1'b0;
                drain();
                if (p == 2) begin
                    write_reg(REG_SPARE_LO, 11'h7FF);
                    write_reg(REG_SPARE_HI, 11'h000);
                end
                write_reg(mboxc_pkg::REG_ROW_WIDTH, ph_width[p]);
                write_reg(mboxc_pkg::REG_WINDOW_ROWS, ph_rows[p]);
                write_reg(mboxc_pkg::REG_WINDOW_COLS, ph_cols[p]);
                write_reg(mboxc_pkg::REG_NUM_IMAGES, ph_imgs[p]);
                write_reg(mboxc_pkg::REG_MASK_ENABLE, ph_mask[p]);
                cfg_valid <= 1'b0;
            end
            for (int i = 0; i < ph_items[p]; i++) begin
                if (p < 2)
                    send_item(edge_vals[i % 8], (i % 3) != 2, i == 0 || i == 13);
                else
                    send_item(pick_sample(), $urandom_range(0, 3) != 0,
                              i == 0 || $urandom_range(0, 59) == 0);
            end
        end
        s_tvalid <= 1'b0;
        drain();
        $display("ran %0d register settings, %0d sample items in, %0d mean items out",
                 NUM_PHASES, items_sent, mean_count);
        $display("covered width and window saturation, masking, frame restarts, stalls");
        if (fail_count == 0)
            $display("multi_image_boxcar_mean_test OK");
        else
            $display("multi_image_boxcar_mean_test NOT OK");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/mboxc_pkg.sv
design/mboxc_cell.sv
design/mboxc_div.sv
design/multi_image_boxcar_mean.sv
tb/multi_image_boxcar_mean_checker.sv
tb/multi_image_boxcar_mean_test.sv
